// ----- rtl/core/cmsc_pkg.sv -----
// Shared types, constants and helper functions for the color marker seed collector.
package cmsc_pkg;

   localparam int SEED_SLOTS  = 64;
   localparam int COORD_BITS  = 10;
   localparam int CNT_BITS    = $clog2(SEED_SLOTS + 1);
   localparam int NUM_CLASSES = 5;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 10;

   localparam logic [CNT_BITS-1:0] SEED_LIMIT = CNT_BITS'(SEED_SLOTS);

   // color class codes
   localparam logic [2:0] CLS_NONE     = 3'd0;
   localparam logic [2:0] CLS_BLUE     = 3'd1;
   localparam logic [2:0] CLS_GREEN    = 3'd2;
   localparam logic [2:0] CLS_RED      = 3'd3;
   localparam logic [2:0] CLS_YELLOW   = 3'd4;
   localparam logic [2:0] CLS_YELLOW_R = 3'd5;

   // counter row positions
   localparam int IDX_BLUE     = 0;
   localparam int IDX_GREEN    = 1;
   localparam int IDX_RED      = 2;
   localparam int IDX_YELLOW   = 3;
   localparam int IDX_YELLOW_R = 4;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_STRIDE       = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORNER_TOP   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CORNER_RIGHT = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_SEEDS    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_BLUE     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_GREEN    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_RED      = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_CORNER   = 3'd7;

   // color thresholds
   localparam logic [8:0] BLUE_B_MIN   = 9'd190;
   localparam logic [8:0] BLUE_R_MAX   = 9'd60;
   localparam logic [8:0] BLUE_DIFF    = 9'd45;
   localparam logic [8:0] GREEN_G_MIN  = 9'd200;
   localparam logic [8:0] GREEN_R_MAX  = 9'd50;
   localparam logic [8:0] GREEN_DIFF   = 9'd19;
   localparam logic [8:0] RED_BG_MAX   = 9'd40;
   localparam logic [8:0] RED_R_MIN    = 9'd205;
   localparam logic [8:0] YEL_B_MAX    = 9'd95;
   localparam logic [8:0] YEL_G_MIN    = 9'd70;
   localparam logic [8:0] YEL_R_MIN    = 9'd122;

   localparam int MOD_DIGITS = (COORD_BITS + 1) / 2;

   typedef logic [NUM_CLASSES-1:0][CNT_BITS-1:0] cnt_row_type;

   typedef struct packed {
      logic [7:0]            pix_blue;
      logic [7:0]            pix_green;
      logic [7:0]            pix_red;
      logic [COORD_BITS-1:0] pix_x;
      logic [COORD_BITS-1:0] pix_y;
      logic                  frame_end;
   } pix_req_type;

   typedef struct packed {
      logic [2:0]          color_class;
      logic                seed_kept;
      logic [5:0]          seed_slot;
      logic                frame_done;
      logic                too_few;
      logic [CNT_BITS-1:0] count_blue;
      logic [CNT_BITS-1:0] count_green;
      logic [CNT_BITS-1:0] count_red;
      logic [CNT_BITS-1:0] count_left_yellow;
      logic [CNT_BITS-1:0] count_right_yellow;
   } seed_rsp_type;

   // effective stride: 0 acts as 1, 5..7 act as 4
   function automatic logic [2:0] stride_of(input logic [2:0] code);
      logic [2:0] s;
      case (code)
         3'd0:    s = 3'd1;
         3'd1:    s = 3'd1;
         3'd2:    s = 3'd2;
         3'd3:    s = 3'd3;
         default: s = 3'd4;
      endcase
      return s;
   endfunction

   // v mod 3: 4 == 1 mod 3, so sum the base-4 digits
   function automatic logic [1:0] mod3(input logic [COORD_BITS-1:0] v);
      logic [2*MOD_DIGITS-1:0] p;
      logic [2:0]              r;
      p = (2*MOD_DIGITS)'(v);
      r = 3'd0;
      for (int i = 0; i < MOD_DIGITS; i++) begin
         r = r + {1'b0, p[2*i +: 2]};
         if (r >= 3'd3) r = r - 3'd3;
      end
      return r[1:0];
   endfunction

   function automatic logic [2:0] classify(input logic [7:0] b, input logic [7:0] g,
                                           input logic [7:0] r);
      logic [8:0] bb, gg, rr;
      logic [2:0] c;
      bb = {1'b0, b};
      gg = {1'b0, g};
      rr = {1'b0, r};
      c  = CLS_NONE;
      if (bb > BLUE_B_MIN && rr < BLUE_R_MAX && bb > gg + BLUE_DIFF) c = CLS_BLUE;
      if (gg > GREEN_G_MIN && rr < GREEN_R_MAX && gg > bb + GREEN_DIFF) c = CLS_GREEN;
      if (bb < RED_BG_MAX && gg < RED_BG_MAX && rr > RED_R_MIN) c = CLS_RED;
      if (c == CLS_NONE && bb < YEL_B_MAX && gg > YEL_G_MIN && rr > YEL_R_MIN)
         c = CLS_YELLOW;
      return c;
   endfunction

endpackage

// ----- rtl/core/color_marker_seed_collector_core.sv -----
// Top level of the color marker seed collector: classifier, seed counter memory, result register.
//
// Takes one pixel request per clock and returns one result per pixel. The pixel is classified
// into the stage 1 register when the request is accepted; when that stage advances, the counter
// row is updated and written back while the result register is loaded.
// The per-class seed counters live in a one-row
// synchronous memory read every cycle; a write-to-read bypass keeps back-to-back pixels exact,
// so the sustained rate is one pixel per cycle as long as rsp_ready stays high. The result
// register lets a new pixel enter while an earlier result waits. After reset the counter row
// reads as zero until first written; no clearing pass is needed. Registers are written through
// the csr_ port, always ready; the user must write them only while the block is idle (unenforced).
module color_marker_seed_collector_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cmsc_pkg::pix_req_type               req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cmsc_pkg::seed_rsp_type              rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cmsc_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [cmsc_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import cmsc_pkg::*;

   localparam int CNT_ROWS = 1;

   // configuration
   logic [2:0]            stride_ff;
   logic [COORD_BITS-1:0] corner_top_ff;
   logic [COORD_BITS-1:0] corner_right_ff;
   logic [CNT_BITS-1:0]   max_seeds_ff;
   logic [CNT_BITS-1:0]   min_blue_ff;
   logic [CNT_BITS-1:0]   min_green_ff;
   logic [CNT_BITS-1:0]   min_red_ff;
   logic [CNT_BITS-1:0]   min_corner_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff       <= 3'd3;
         corner_top_ff   <= COORD_BITS'(110);
         corner_right_ff <= COORD_BITS'(300);
         max_seeds_ff    <= CNT_BITS'(35);
         min_blue_ff     <= CNT_BITS'(10);
         min_green_ff    <= CNT_BITS'(10);
         min_red_ff      <= CNT_BITS'(10);
         min_corner_ff   <= CNT_BITS'(3);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STRIDE:       stride_ff       <= csr_wdata[2:0];
            CSR_CORNER_TOP:   corner_top_ff   <= csr_wdata[COORD_BITS-1:0];
            CSR_CORNER_RIGHT: corner_right_ff <= csr_wdata[COORD_BITS-1:0];
            CSR_MAX_SEEDS:    max_seeds_ff    <= csr_wdata[CNT_BITS-1:0];
            CSR_MIN_BLUE:     min_blue_ff     <= csr_wdata[CNT_BITS-1:0];
            CSR_MIN_GREEN:    min_green_ff    <= csr_wdata[CNT_BITS-1:0];
            CSR_MIN_RED:      min_red_ff      <= csr_wdata[CNT_BITS-1:0];
            CSR_MIN_CORNER:   min_corner_ff   <= csr_wdata[CNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // stage 0: sampling and classification on the incoming request
   logic       sampled;
   logic [2:0] cls_raw;
   logic [2:0] cls_in;

   always_comb begin
      case (stride_of(stride_ff))
         3'd1: sampled = 1'b1;
         3'd2: sampled = !req_payload.pix_x[0] && !req_payload.pix_y[0];
         3'd3: sampled = (mod3(req_payload.pix_x) == 2'd0) && (mod3(req_payload.pix_y) == 2'd0);
         default: sampled = (req_payload.pix_x[1:0] == 2'd0) && (req_payload.pix_y[1:0] == 2'd0);
      endcase
      cls_raw = classify(req_payload.pix_blue, req_payload.pix_green, req_payload.pix_red);
      cls_in  = CLS_NONE;
      if (sampled) begin
         cls_in = cls_raw;
         if (cls_raw == CLS_YELLOW && req_payload.pix_y > corner_top_ff &&
             req_payload.pix_x > corner_right_ff)
            cls_in = CLS_YELLOW_R;
      end
   end

   // stage 1 register
   logic       s1_vld_ff;
   logic [2:0] s1_cls_ff;
   logic       s1_last_ff;
   logic       s1_adv;
   logic       rsp_vld_ff;
   logic       rsp_free;

   assign rsp_free  = !rsp_vld_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && rsp_free;
   assign req_ready = !s1_vld_ff || rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cls_ff  <= cls_in;
         s1_last_ff <= req_payload.frame_end;
      end
   end

   // counter row memory, read every cycle, bypassed after a write
   cnt_row_type cnt_mem [CNT_ROWS];
   cnt_row_type rd_ff;
   cnt_row_type wr_ff;
   cnt_row_type wr_in;
   logic        fwd_ff;
   logic        row_vld_ff;
   cnt_row_type cnt_cur;

   always_ff @(posedge clock) begin
      if (s1_adv) cnt_mem[0] <= wr_in;
      rd_ff <= cnt_mem[0];
      wr_ff <= wr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff     <= 1'b0;
         row_vld_ff <= 1'b0;
      end else begin
         fwd_ff <= s1_adv;
         if (s1_adv) row_vld_ff <= 1'b1;
      end
   end

   assign cnt_cur = !row_vld_ff ? '0 : (fwd_ff ? wr_ff : rd_ff);

   // stage 1: update the class counter and build the result
   logic [CNT_BITS-1:0] limit;
   logic [CNT_BITS-1:0] sel_cnt;
   logic                kept;
   cnt_row_type         cnt_new;
   logic                few;
   seed_rsp_type        rsp_in;
   seed_rsp_type        rsp_ff;

   always_comb begin
      limit = (max_seeds_ff > SEED_LIMIT) ? SEED_LIMIT : max_seeds_ff;
      case (s1_cls_ff)
         CLS_BLUE:     sel_cnt = cnt_cur[IDX_BLUE];
         CLS_GREEN:    sel_cnt = cnt_cur[IDX_GREEN];
         CLS_RED:      sel_cnt = cnt_cur[IDX_RED];
         CLS_YELLOW:   sel_cnt = cnt_cur[IDX_YELLOW];
         CLS_YELLOW_R: sel_cnt = cnt_cur[IDX_YELLOW_R];
         default:      sel_cnt = '0;
      endcase
      kept    = (s1_cls_ff != CLS_NONE) && (sel_cnt < limit);
      cnt_new = cnt_cur;
      if (kept) begin
         case (s1_cls_ff)
            CLS_BLUE:     cnt_new[IDX_BLUE]     = sel_cnt + CNT_BITS'(1);
            CLS_GREEN:    cnt_new[IDX_GREEN]    = sel_cnt + CNT_BITS'(1);
            CLS_RED:      cnt_new[IDX_RED]      = sel_cnt + CNT_BITS'(1);
            CLS_YELLOW:   cnt_new[IDX_YELLOW]   = sel_cnt + CNT_BITS'(1);
            default:      cnt_new[IDX_YELLOW_R] = sel_cnt + CNT_BITS'(1);
         endcase
      end
      few = s1_last_ff && (cnt_new[IDX_BLUE] < min_blue_ff ||
                           cnt_new[IDX_GREEN] < min_green_ff ||
                           cnt_new[IDX_RED] < min_red_ff ||
                           cnt_new[IDX_YELLOW] < min_corner_ff ||
                           cnt_new[IDX_YELLOW_R] < min_corner_ff);
      wr_in = s1_last_ff ? '0 : cnt_new;

      rsp_in.color_class        = s1_cls_ff;
      rsp_in.seed_kept          = kept;
      rsp_in.seed_slot          = kept ? sel_cnt[5:0] : 6'd0;
      rsp_in.frame_done         = s1_last_ff;
      rsp_in.too_few            = few;
      rsp_in.count_blue         = cnt_new[IDX_BLUE];
      rsp_in.count_green        = cnt_new[IDX_GREEN];
      rsp_in.count_red          = cnt_new[IDX_RED];
      rsp_in.count_left_yellow  = cnt_new[IDX_YELLOW];
      rsp_in.count_right_yellow = cnt_new[IDX_YELLOW_R];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_ff;

   // a kept seed always gets a slot below the seed limit
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && kept |-> {1'b0, sel_cnt} < {1'b0, limit})
      else $error("seed slot at or above limit");

   // too_few is only reported with frame_done
   assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.too_few |-> rsp_ff.frame_done)
      else $error("too_few without frame_done");

   // counters read as zero right after a frame ends
   assert property (@(posedge clock) disable iff (reset)
      s1_adv && s1_last_ff |=> cnt_cur == '0)
      else $error("counters not cleared after frame end");

   // no class counter exceeds the slot count
   assert property (@(posedge clock) disable iff (reset)
      cnt_cur[IDX_BLUE] <= SEED_LIMIT && cnt_cur[IDX_GREEN] <= SEED_LIMIT &&
      cnt_cur[IDX_RED] <= SEED_LIMIT && cnt_cur[IDX_YELLOW] <= SEED_LIMIT &&
      cnt_cur[IDX_YELLOW_R] <= SEED_LIMIT)
      else $error("class counter above slot count");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the color marker seed collector core.
module tb_top;
   import cmsc_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int MAX_PRINTS  = 40;

   // color thresholds of the classifier
   localparam int BLUE_MIN   = 190;
   localparam int BLUE_RMAX  = 60;
   localparam int BLUE_GAP   = 45;
   localparam int GREEN_MIN  = 200;
   localparam int GREEN_RMAX = 50;
   localparam int GREEN_GAP  = 19;
   localparam int RED_BGMAX  = 40;
   localparam int RED_MIN    = 205;
   localparam int YEL_BMAX   = 95;
   localparam int YEL_GMIN   = 70;
   localparam int YEL_RMIN   = 122;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic         req_valid   = 1'b0;
   logic         req_ready;
   pix_req_type  req_payload = '0;
   logic         rsp_valid;
   logic         rsp_ready   = 1'b0;
   seed_rsp_type rsp_payload;
   logic         csr_valid   = 1'b0;
   logic         csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // shadow registers and seed counters of the predictor
   logic [2:0]          cfg_stride;
   logic [9:0]          cfg_corner_top;
   logic [9:0]          cfg_corner_right;
   logic [6:0]          cfg_max_seeds;
   logic [6:0]          cfg_min_blue;
   logic [6:0]          cfg_min_green;
   logic [6:0]          cfg_min_red;
   logic [6:0]          cfg_min_corner;
   logic [CNT_BITS-1:0] seed_count [NUM_CLASSES];

   seed_rsp_type seed_results_due [$];

   int  n_errors      = 0;
   int  n_results     = 0;
   int  n_frames      = 0;
   int  n_kept        = 0;
   int  n_too_few     = 0;
   int  items_sent    = 0;
   int  config_count  = 0;
   int  cycle_count   = 0;
   bit  idle_on       = 1'b1;

   color_marker_seed_collector_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still due", cycle_count,
                  seed_results_due.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (n_errors < MAX_PRINTS)
         $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
      n_errors++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s got %0d expected %0d",
                                   n_results, name, got, want));
   endtask

   // classify one pixel, update the seed counters, build the expected result
   function automatic seed_rsp_type classify_and_count(input pix_req_type p);
      seed_rsp_type r;
      int           pitch, limit, b, g, rd, x, y, k;
      logic [2:0]   cls;
      r     = '0;
      b     = int'(p.pix_blue);
      g     = int'(p.pix_green);
      rd    = int'(p.pix_red);
      x     = int'(p.pix_x);
      y     = int'(p.pix_y);
      cls   = CLS_NONE;
      case (cfg_stride)
         3'd0, 3'd1: pitch = 1;
         3'd2:       pitch = 2;
         3'd3:       pitch = 3;
         default:    pitch = 4;
      endcase
      limit = (int'(cfg_max_seeds) > SEED_SLOTS) ? SEED_SLOTS : int'(cfg_max_seeds);
      if (x % pitch == 0 && y % pitch == 0) begin
         if (b > BLUE_MIN && rd < BLUE_RMAX && b - g > BLUE_GAP) cls = CLS_BLUE;
         if (g > GREEN_MIN && rd < GREEN_RMAX && g - b > GREEN_GAP) cls = CLS_GREEN;
         if (b < RED_BGMAX && g < RED_BGMAX && rd > RED_MIN) cls = CLS_RED;
         if (cls == CLS_NONE && b < YEL_BMAX && g > YEL_GMIN && rd > YEL_RMIN)
            cls = CLS_YELLOW;
         if (cls == CLS_YELLOW && y > int'(cfg_corner_top) && x > int'(cfg_corner_right))
            cls = CLS_YELLOW_R;
         if (cls != CLS_NONE) begin
            // class codes 1..5 line up with counter rows 0..4
            k = int'(cls) - 1;
            if (int'(seed_count[k]) < limit) begin
               r.seed_kept   = 1'b1;
               r.seed_slot   = seed_count[k][5:0];
               seed_count[k] = seed_count[k] + CNT_BITS'(1);
            end
         end
      end
      r.color_class = cls;
      r.frame_done  = p.frame_end;
      if (p.frame_end)
         r.too_few = seed_count[IDX_BLUE] < cfg_min_blue ||
                     seed_count[IDX_GREEN] < cfg_min_green ||
                     seed_count[IDX_RED] < cfg_min_red ||
                     seed_count[IDX_YELLOW] < cfg_min_corner ||
                     seed_count[IDX_YELLOW_R] < cfg_min_corner;
      r.count_blue         = seed_count[IDX_BLUE];
      r.count_green        = seed_count[IDX_GREEN];
      r.count_red          = seed_count[IDX_RED];
      r.count_left_yellow  = seed_count[IDX_YELLOW];
      r.count_right_yellow = seed_count[IDX_YELLOW_R];
      if (p.frame_end)
         for (k = 0; k < NUM_CLASSES; k++) seed_count[k] = '0;
      return r;
   endfunction

   // predicts on every accepted request and checks every accepted result
   always @(posedge clock) begin : result_check
      seed_rsp_type want;
      if (reset) begin
         cfg_stride       = 3'd3;
         cfg_corner_top   = 10'd110;
         cfg_corner_right = 10'd300;
         cfg_max_seeds    = 7'd35;
         cfg_min_blue     = 7'd10;
         cfg_min_green    = 7'd10;
         cfg_min_red      = 7'd10;
         cfg_min_corner   = 7'd3;
         for (int k = 0; k < NUM_CLASSES; k++) seed_count[k] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STRIDE:       cfg_stride       = csr_wdata[2:0];
               CSR_CORNER_TOP:   cfg_corner_top   = csr_wdata[9:0];
               CSR_CORNER_RIGHT: cfg_corner_right = csr_wdata[9:0];
               CSR_MAX_SEEDS:    cfg_max_seeds    = csr_wdata[6:0];
               CSR_MIN_BLUE:     cfg_min_blue     = csr_wdata[6:0];
               CSR_MIN_GREEN:    cfg_min_green    = csr_wdata[6:0];
               CSR_MIN_RED:      cfg_min_red      = csr_wdata[6:0];
               CSR_MIN_CORNER:   cfg_min_corner   = csr_wdata[6:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            seed_results_due.push_back(classify_and_count(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (seed_results_due.size() == 0) begin
               report_mismatch("result arrived with no request outstanding");
            end else begin
               want = seed_results_due.pop_front();
               compare_field("color_class", 32'(rsp_payload.color_class),
                             32'(want.color_class));
               compare_field("seed_kept", 32'(rsp_payload.seed_kept), 32'(want.seed_kept));
               compare_field("seed_slot", 32'(rsp_payload.seed_slot), 32'(want.seed_slot));
               compare_field("frame_done", 32'(rsp_payload.frame_done),
                             32'(want.frame_done));
               compare_field("too_few", 32'(rsp_payload.too_few), 32'(want.too_few));
               compare_field("count_blue", 32'(rsp_payload.count_blue),
                             32'(want.count_blue));
               compare_field("count_green", 32'(rsp_payload.count_green),
                             32'(want.count_green));
               compare_field("count_red", 32'(rsp_payload.count_red), 32'(want.count_red));
               compare_field("count_left_yellow", 32'(rsp_payload.count_left_yellow),
                             32'(want.count_left_yellow));
               compare_field("count_right_yellow", 32'(rsp_payload.count_right_yellow),
                             32'(want.count_right_yellow));
               if (want.frame_done) n_frames++;
               if (want.seed_kept) n_kept++;
               if (want.too_few) n_too_few++;
            end
            n_results++;
         end
      end
   end

   // result side back-pressure: a random stall, possibly none, ahead of every result while idle_on is set
   initial begin : rsp_stall
      int stall;
      @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 12) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // returns at the edge where the request is taken; valid stays up for back-to-back
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                             input logic [9:0] x, input logic [9:0] y, input logic last);
      pix_req_type p;
      int          gap;
      p.pix_blue  = b;
      p.pix_green = g;
      p.pix_red   = r;
      p.pix_x     = x;
      p.pix_y     = y;
      p.frame_end = last;
      gap = idle_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (seed_results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_BITS-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic write_config(input int stride, input int top, input int right,
                               input int max_s, input int mb, input int mg, input int mr,
                               input int mc);
      wait_drain();
      csr_write(CSR_STRIDE, stride);
      csr_write(CSR_CORNER_TOP, top);
      csr_write(CSR_CORNER_RIGHT, right);
      csr_write(CSR_MAX_SEEDS, max_s);
      csr_write(CSR_MIN_BLUE, mb);
      csr_write(CSR_MIN_GREEN, mg);
      csr_write(CSR_MIN_RED, mr);
      csr_write(CSR_MIN_CORNER, mc);
      csr_valid <= 1'b0;
      @(posedge clock);
      config_count++;
   endtask

   // channel values near the thresholds of one class, or anything for other codes
   function automatic logic [23:0] pick_color(input logic [2:0] kind);
      int b, g, r;
      case (kind)
         CLS_BLUE: begin
            b = $urandom_range(185, 255);
            g = b - $urandom_range(40, b);
            r = $urandom_range(0, 65);
         end
         CLS_GREEN: begin
            g = $urandom_range(195, 255);
            b = g - $urandom_range(15, g);
            r = $urandom_range(0, 55);
         end
         CLS_RED: begin
            b = $urandom_range(0, 45);
            g = $urandom_range(0, 45);
            r = $urandom_range(200, 255);
         end
         CLS_YELLOW: begin
            b = $urandom_range(0, 100);
            g = $urandom_range(65, 255);
            r = $urandom_range(117, 255);
         end
         default: begin
            b = $urandom_range(0, 255);
            g = $urandom_range(0, 255);
            r = $urandom_range(0, 255);
         end
      endcase
      return {b[7:0], g[7:0], r[7:0]};
   endfunction

   // column-major scans of a small window, with some noise frames mixed in
   task automatic run_frames(input int n_items);
      int          sent0, len, h, x0, y0, pitch, i;
      logic [23:0] c;
      logic [9:0]  x, y;
      logic        last, noise;
      sent0 = items_sent;
      while (items_sent - sent0 < n_items) begin
         len   = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
         noise = ($urandom_range(0, 7) == 0);
         h     = $urandom_range(1, 16);
         pitch = $urandom_range(1, 4);
         x0    = pitch * $urandom_range(0, 255);
         y0    = pitch * $urandom_range(0, 255);
         for (i = 0; i < len; i++) begin
            c = pick_color(3'($urandom_range(0, 5)));
            if (noise) begin
               x    = 10'($urandom);
               y    = 10'($urandom);
               last = ($urandom_range(0, 7) == 0);
            end else begin
               x    = 10'(x0 + pitch * (i / h));
               y    = 10'(y0 + pitch * (i % h));
               last = (i == len - 1);
            end
            send_pixel(c[23:16], c[15:8], c[7:0], x, y, last);
         end
      end
   endtask

   // reset settings: stride 3, corner past y 110 and x 300
   task automatic test_thresholds();
      send_pixel(8'd0, 8'd0, 8'd0, 10'd0, 10'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 10'd1023, 10'd1023, 1'b0);
      send_pixel(8'd191, 8'd145, 8'd59, 10'd3, 10'd3, 1'b0);
      send_pixel(8'd190, 8'd100, 8'd0, 10'd6, 10'd6, 1'b0);
      send_pixel(8'd255, 8'd210, 8'd0, 10'd9, 10'd9, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd60, 10'd12, 10'd12, 1'b0);
      send_pixel(8'd181, 8'd201, 8'd49, 10'd15, 10'd15, 1'b0);
      send_pixel(8'd182, 8'd201, 8'd49, 10'd15, 10'd18, 1'b0);
      send_pixel(8'd0, 8'd200, 8'd0, 10'd18, 10'd15, 1'b0);
      send_pixel(8'd39, 8'd39, 8'd206, 10'd18, 10'd18, 1'b0);
      send_pixel(8'd40, 8'd0, 8'd255, 10'd21, 10'd18, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd205, 10'd21, 10'd21, 1'b0);
      send_pixel(8'd94, 8'd71, 8'd123, 10'd21, 10'd24, 1'b0);
      send_pixel(8'd95, 8'd71, 8'd123, 10'd24, 10'd24, 1'b0);
      send_pixel(8'd94, 8'd70, 8'd255, 10'd24, 10'd27, 1'b0);
      send_pixel(8'd94, 8'd255, 8'd122, 10'd27, 10'd27, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 10'd303, 10'd111, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 10'd300, 10'd111, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd255, 10'd303, 10'd108, 1'b0);
      // off the sampling grid in one axis only
      send_pixel(8'd0, 8'd0, 8'd255, 10'd1, 10'd0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 10'd0, 10'd1, 1'b0);
      // last pixel is counted before the report
      send_pixel(8'd255, 8'd0, 8'd0, 10'd0, 10'd3, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 10'd3, 10'd0, 1'b1);
   endtask

   // every stride code, including the ones that fold to 1 and 4
   task automatic test_stride_codes();
      for (int code = 0; code < 8; code++) begin
         write_config(code, $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(1, 64), $urandom_range(0, 4), $urandom_range(0, 4),
                      $urandom_range(0, 4), $urandom_range(0, 2));
         for (int i = 0; i < 10; i++) begin
            logic [23:0] c;
            c = pick_color(3'($urandom_range(0, 5)));
            send_pixel(c[23:16], c[15:8], c[7:0], 10'($urandom_range(0, 15)),
                       10'($urandom_range(0, 15)), i == 9);
         end
      end
   endtask

   task automatic test_seed_limits();
      // no seeds at all
      write_config(1, 0, 0, 0, 0, 0, 0, 0);
      for (int i = 0; i < 5; i++)
         send_pixel(8'd0, 8'd0, 8'd255, 10'(i), 10'd0, i == 4);
      // limit above the slot count folds to 64: fill red past its last slot
      write_config(1, 1023, 1023, 127, 64, 64, 64, 64);
      for (int i = 0; i < 68; i++)
         send_pixel(8'd0, 8'd0, 8'd255, 10'(i), 10'd5, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd0, 10'd0, 10'd0, 1'b1);
      // one seed per class, minimum met everywhere, then minimums out of reach
      write_config(2, 0, 0, 1, 1, 1, 1, 1);
      for (int pass = 0; pass < 2; pass++) begin
         for (int i = 0; i < 2; i++) begin
            send_pixel(8'd255, 8'd0, 8'd0, 10'd2, 10'd2, 1'b0);
            send_pixel(8'd0, 8'd255, 8'd0, 10'd2, 10'd4, 1'b0);
            send_pixel(8'd0, 8'd0, 8'd255, 10'd4, 10'd2, 1'b0);
            send_pixel(8'd0, 8'd255, 8'd255, 10'd0, 10'd8, 1'b0);
            send_pixel(8'd0, 8'd255, 8'd255, 10'd8, 10'd8, 1'b0);
         end
         send_pixel(8'd0, 8'd0, 8'd0, 10'd1, 10'd1, 1'b1);
         if (pass == 0) write_config(2, 0, 0, 1, 127, 127, 127, 127);
      end
   endtask

   task automatic test_random_frames();
      for (int batch = 0; batch < 8; batch++) begin
         case (batch)
            0: write_config(1, 0, 0, 0, 0, 0, 0, 0);
            1: write_config(4, 1023, 1023, 64, 64, 64, 64, 64);
            2: write_config(7, 0, 0, 127, 127, 127, 127, 127);
            default: write_config($urandom_range(0, 7), $urandom_range(0, 1023),
                                  $urandom_range(0, 1023),
                                  $urandom_range(0, 1) ? $urandom_range(0, 6)
                                                       : $urandom_range(0, 127),
                                  $urandom_range(0, 6), $urandom_range(0, 6),
                                  $urandom_range(0, 6),
                                  $urandom_range(0, 3) ? $urandom_range(0, 3)
                                                       : $urandom_range(0, 127));
         endcase
         idle_on = (batch == 3) ? 1'b0 : ($urandom_range(0, 3) != 0);
         run_frames(70);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_thresholds();
      test_stride_codes();
      test_seed_limits();
      test_random_frames();
      wait_drain();
      repeat (10) @(posedge clock);
      if (seed_results_due.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   seed_results_due.size()));
      $display("ran %0d pixels in %0d frames over %0d register settings",
               items_sent, n_frames, config_count);
      $display("%0d seeds kept, %0d frames flagged short, %0d mismatches",
               n_kept, n_too_few, n_errors);
      if (n_errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
